// File: rtl/tsm_pkg.sv
package tsm_pkg;

    // Operation codes
    localparam logic [1:0] OP_EVENT  = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Trigger kinds
    localparam logic [1:0] KIND_GESTURE = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;

    // Status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_ID = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATHER_WINDOW     = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [7:0]  DEFAULT_THRESHOLD_RST = 8'd50;
    localparam logic [15:0] GATHER_WINDOW_RST     = 16'd5000;

    // Gestures 1..GESTURES each own one gathered bit
    localparam int unsigned GESTURES = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  slot_id;
        logic [1:0]  trigger_kind;
        logic [15:0] key_value;
        logic        has_confidence;
        logic [6:0]  confidence_pct;
        logic [31:0] now_ms;
        logic [15:0] min_gap_ms;
        logic [7:0]  slot_threshold_pct;
        logic        has_steps;
    } t_req;

    typedef struct packed {
        logic [7:0] fired_mask;
        logic [7:0] suppressed_mask;
        logic [7:0] empty_match_mask;
        logic       status;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted request
        logic exec;     // run store/delete, clear result masks
        logic scan;     // evaluate the slot at the walk index
        logic push;     // move the finished result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_event;
    } t_dp_sts;

endpackage

// File: rtl/tsm_req_if.sv
interface tsm_req_if import tsm_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tsm_rsp_if.sv
interface tsm_rsp_if import tsm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tsm_cfg_if.sv
interface tsm_cfg_if import tsm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/trigger_slot_matcher_core.sv
// Trigger slot matcher. Keeps SLOTS trigger slots and answers every request
// with exactly one result. Store (operation 1) and delete (operation 2) write
// or clear slot slot_id (1..SLOTS, anything else returns status 1); an event
// (operation 0) is checked against every valid slot of its kind and reports
// fired, suppressed (within cooldown) and empty-match (no steps) masks, with
// bit i for slot i+1, so slots above 8 take part but never show up in the
// masks. Operation 3 returns an all-zero result. Timing: a request is taken
// only while the block is idle; for an event the controller runs a setup
// step, walks the slot table one entry per cycle through a single
// evaluation unit and then loads the output register; store, delete and
// no-op requests skip the walk. The load waits while an earlier result in
// the output register has not been taken. The block is idle again once
// the result is loaded, so the next request is taken while that result
// waits in the output register. Configuration writes are always accepted
// and should be issued only while the block is idle.
module trigger_slot_matcher_core import tsm_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsm_req_if.sink   i_req,
    tsm_rsp_if.source o_rsp,
    tsm_cfg_if.sink   i_cfg
);

    // Walk index width; one bit minimum for a single-slot table
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [IW-1:0] idx;

    // Configuration registers take a write on every cycle
    assign i_cfg.ready = 1'b1;

    // Controller: sequences capture, store/delete, slot walk and result push
    tsm_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    // Datapath: slot table, match evaluation, result masks
    tsm_dp #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_req_data  (i_req.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_wdata (i_cfg.wdata),
        .o_sts       (sts),
        .o_rsp_data  (o_rsp.data)
    );

    // A request is latched only on an accepted handshake
    a_capture_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (i_req.valid && i_req.ready))
        else $error("request latched without handshake");

    // Never overwrite a result that is still waiting to be taken
    a_push_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result pushed over a pending result");

    // No new request while the slot walk is running
    a_busy_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan |-> !i_req.ready)
        else $error("request taken during slot walk");

    // A pushed result shows up on the output next cycle
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> o_rsp.valid)
        else $error("pushed result not presented");

endmodule

// File: rtl/tsm_ctrl.sv
module tsm_ctrl import tsm_pkg::*; #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_idx
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_idx;
    logic          r_out_valid;
    logic          accept;
    logic          last_slot;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign last_slot   = (r_idx == IW'(SLOTS - 1));

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = accept;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.push    = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);
    end

    assign o_idx       = r_idx;
    assign o_rsp_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_idx <= '0;
                    r_state <= i_sts.is_event ? S_SCAN : S_DONE;
                end
                S_SCAN: begin
                    if (last_slot) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DONE: begin
                    if (o_cmd.push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/tsm_dp.sv
module tsm_dp import tsm_pkg::*; #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [IW-1:0]         i_idx,
    input  t_req                  i_req_data,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_dp_sts               o_sts,
    output t_rsp                  o_rsp_data
);

    // Slot table
    logic        r_valid   [SLOTS];
    logic [1:0]  r_kind    [SLOTS];
    logic [15:0] r_value   [SLOTS];
    logic [15:0] r_cd      [SLOTS];
    logic [7:0]  r_thr     [SLOTS];
    logic        r_steps   [SLOTS];
    logic [31:0] r_lft     [SLOTS];
    logic [GESTURES-1:0] r_gbits [SLOTS];
    logic [31:0] r_gtime   [SLOTS];

    logic [7:0]  r_def_thr;
    logic [15:0] r_window;

    t_req        r_req;
    logic [7:0]  r_fired;
    logic [7:0]  r_supp;
    logic [7:0]  r_empty;
    logic        r_status;
    t_rsp        r_rsp;

    logic          id_ok;
    logic [IW-1:0] s_slot;
    logic          do_store;
    logic          do_delete;

    logic                kind_hit;
    logic                gmode;
    logic [GESTURES-1:0] gbit;
    logic [7:0]          thr;
    logic                gest_ok;
    logic [31:0]         age_g;
    logic                expired;
    logic [GESTURES-1:0] newbits;
    logic                full;
    logic                match;
    logic [31:0]         age_f;
    logic                in_cd;
    logic [7:0]          sbit;

    assign id_ok     = (r_req.slot_id != 8'd0) && ({1'b0, r_req.slot_id} <= 9'(SLOTS));
    assign s_slot    = IW'(r_req.slot_id - 8'd1);
    assign do_store  = i_cmd.exec && id_ok && (r_req.operation == OP_STORE);
    assign do_delete = i_cmd.exec && id_ok && (r_req.operation == OP_DELETE);

    assign o_sts.is_event = (r_req.operation == OP_EVENT);
    assign o_rsp_data     = r_rsp;

    // Evaluate one slot per scan step
    always_comb begin
        kind_hit = r_valid[i_idx] && (r_kind[i_idx] == r_req.trigger_kind);
        gmode    = (r_req.trigger_kind == KIND_GESTURE) && r_req.has_confidence;
        for (int g = 0; g < GESTURES; g++) begin
            gbit[g] = (r_req.key_value == 16'(g + 1));
        end
        thr     = (r_thr[i_idx] != 8'd0) ? r_thr[i_idx] : r_def_thr;
        gest_ok = (|(gbit & r_value[i_idx][GESTURES:1]))
                  && ({1'b0, r_req.confidence_pct} >= thr);
        age_g   = r_req.now_ms - r_gtime[i_idx];
        expired = (r_gtime[i_idx] != 32'd0) && (age_g > {16'd0, r_window});
        newbits = (expired ? '0 : r_gbits[i_idx]) | gbit;
        // Bits outside gestures 1..4 can never be gathered
        full    = (r_value[i_idx][0] == 1'b0)
                  && (r_value[i_idx][15:GESTURES+1] == '0)
                  && ((r_value[i_idx][GESTURES:1] & ~newbits) == '0);
        match   = gmode ? (gest_ok && full) : (r_value[i_idx] == r_req.key_value);
        age_f   = r_req.now_ms - r_lft[i_idx];
        in_cd   = (r_cd[i_idx] != 16'd0) && (age_f < {16'd0, r_cd[i_idx]});
        sbit    = 8'd1 << i_idx;
    end

    // Control-relevant slot state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_lft[i]   <= '0;
                r_gbits[i] <= '0;
                r_gtime[i] <= '0;
            end
            r_def_thr <= DEFAULT_THRESHOLD_RST;
            r_window  <= GATHER_WINDOW_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DEFAULT_THRESHOLD: r_def_thr <= i_cfg_wdata[7:0];
                    CFG_GATHER_WINDOW:     r_window  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (do_store) begin
                r_valid[s_slot] <= 1'b1;
            end
            if (do_delete) begin
                r_valid[s_slot] <= 1'b0;
                r_lft[s_slot]   <= '0;
            end
            if (i_cmd.scan && kind_hit) begin
                if (gmode && gest_ok) begin
                    r_gbits[i_idx] <= full ? '0 : newbits;
                    r_gtime[i_idx] <= r_req.now_ms;
                end
                if (match && !in_cd && r_steps[i_idx]) begin
                    r_lft[i_idx] <= r_req.now_ms;
                end
            end
        end
    end

    // Slot payload, request latch and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_data;
        end
        if (do_store) begin
            r_kind[s_slot]  <= r_req.trigger_kind;
            r_value[s_slot] <= r_req.key_value;
            r_cd[s_slot]    <= r_req.min_gap_ms;
            r_thr[s_slot]   <= r_req.slot_threshold_pct;
            r_steps[s_slot] <= r_req.has_steps;
        end
        if (i_cmd.exec) begin
            r_fired  <= '0;
            r_supp   <= '0;
            r_empty  <= '0;
            r_status <= ((r_req.operation == OP_STORE) || (r_req.operation == OP_DELETE))
                        && !id_ok ? STATUS_BAD_ID : STATUS_OK;
        end
        if (i_cmd.scan && kind_hit && match) begin
            if (in_cd) begin
                r_supp <= r_supp | sbit;
            end else if (r_steps[i_idx]) begin
                r_fired <= r_fired | sbit;
            end else begin
                r_empty <= r_empty | sbit;
            end
        end
        if (i_cmd.push) begin
            r_rsp.fired_mask       <= r_fired;
            r_rsp.suppressed_mask  <= r_supp;
            r_rsp.empty_match_mask <= r_empty;
            r_rsp.status           <= r_status;
        end
    end

endmodule

// File: test/slot_match_tb_pkg.sv
`timescale 1ns / 100ps

package slot_match_tb_pkg;
    import tsm_pkg::*;

    localparam int TB_SLOTS = 8;

    // Kinds 2 and 3 are both plain value triggers
    localparam logic [1:0] KIND_PLAIN_LO = 2'd2;
    localparam logic [1:0] KIND_PLAIN_HI = 2'd3;

    // Index with no register behind it; writes must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Tracks the slot table and gathered gesture masks, and queues the
    // result each accepted request should produce.
    class slot_match_tracker;
        logic [7:0]  default_pct;
        logic [15:0] window_ms;
        bit          slot_used    [TB_SLOTS];
        logic [1:0]  slot_kind    [TB_SLOTS];
        logic [15:0] slot_key     [TB_SLOTS];
        logic [15:0] slot_cooldown[TB_SLOTS];
        logic [7:0]  slot_pct     [TB_SLOTS];
        bit          slot_steps   [TB_SLOTS];
        logic [31:0] fired_at     [TB_SLOTS];
        logic [3:0]  gathered     [TB_SLOTS];
        logic [31:0] gathered_at  [TB_SLOTS];
        t_rsp        awaited[$];
        int          mismatches;
        int          results_seen;

        function new();
            int s;
            default_pct  = DEFAULT_THRESHOLD_RST;
            window_ms    = GATHER_WINDOW_RST;
            mismatches   = 0;
            results_seen = 0;
            for (s = 0; s < TB_SLOTS; s++) begin
                clear_slot(s);
                gathered[s]    = 4'd0;
                gathered_at[s] = 32'd0;
            end
        endfunction

        // Delete leaves the gathered mask alone
        function void clear_slot(int s);
            slot_used[s]     = 1'b0;
            slot_kind[s]     = 2'd0;
            slot_key[s]      = 16'd0;
            slot_cooldown[s] = 16'd0;
            slot_pct[s]      = 8'd0;
            slot_steps[s]    = 1'b0;
            fired_at[s]      = 32'd0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_DEFAULT_THRESHOLD: default_pct = value[7:0];
                CFG_GATHER_WINDOW:     window_ms   = value;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function bit gather_gesture(int s, t_req r);
            logic [15:0] needed;
            logic [15:0] own_bit;
            logic [7:0]  pass_pct;
            logic [31:0] age;
            needed   = slot_key[s];
            pass_pct = (slot_pct[s] != 8'd0) ? slot_pct[s] : default_pct;
            if (r.key_value < 16'd1 || r.key_value > 16'(GESTURES)) return 1'b0;
            own_bit = 16'd1 << r.key_value;
            if ((needed & own_bit) == 16'd0) return 1'b0;
            if ({1'b0, r.confidence_pct} < pass_pct) return 1'b0;
            // drop a stale partial gather; a zero stamp means never gathered
            age = r.now_ms - gathered_at[s];
            if (gathered_at[s] != 32'd0 && age > {16'd0, window_ms}) gathered[s] = 4'd0;
            gathered[s]    = gathered[s] | own_bit[4:1];
            gathered_at[s] = r.now_ms;
            if (({11'd0, gathered[s], 1'b0} & needed) != needed) return 1'b0;
            gathered[s] = 4'd0;
            return 1'b1;
        endfunction

        function void note_request(t_req r);
            t_rsp        want;
            int          s;
            bit          hit;
            logic [31:0] since;
            want = '0;
            case (r.operation) inside
                OP_STORE, OP_DELETE: begin
                    if (r.slot_id < 8'd1 || r.slot_id > 8'(TB_SLOTS)) begin
                        want.status = STATUS_BAD_ID;
                    end else begin
                        s = int'(r.slot_id) - 1;
                        if (r.operation == OP_STORE) begin
                            slot_used[s]     = 1'b1;
                            slot_kind[s]     = r.trigger_kind;
                            slot_key[s]      = r.key_value;
                            slot_cooldown[s] = r.min_gap_ms;
                            slot_pct[s]      = r.slot_threshold_pct;
                            slot_steps[s]    = r.has_steps;
                        end else begin
                            clear_slot(s);
                        end
                    end
                end
                OP_EVENT: begin
                    for (s = 0; s < TB_SLOTS; s++) begin
                        if (!slot_used[s] || slot_kind[s] != r.trigger_kind) continue;
                        if (r.trigger_kind == KIND_GESTURE && r.has_confidence)
                            hit = gather_gesture(s, r);
                        else
                            hit = (slot_key[s] == r.key_value);
                        if (!hit) continue;
                        since = r.now_ms - fired_at[s];
                        if (slot_cooldown[s] != 16'd0 && since < {16'd0, slot_cooldown[s]}) begin
                            if (s < 8) want.suppressed_mask[s] = 1'b1;
                        end else if (slot_steps[s]) begin
                            if (s < 8) want.fired_mask[s] = 1'b1;
                            fired_at[s] = r.now_ms;
                        end else if (s < 8) begin
                            want.empty_match_mask[s] = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            awaited.push_back(want);
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            mismatches++;
            $display("[%0t] result %0d: %s is %h, want %h",
                     $time, results_seen, what, got, want);
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            results_seen++;
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing awaited, fired_mask", got.fired_mask, 8'd0);
                return;
            end
            want = awaited.pop_front();
            if (got.fired_mask !== want.fired_mask)
                report_mismatch("fired_mask", got.fired_mask, want.fired_mask);
            if (got.suppressed_mask !== want.suppressed_mask)
                report_mismatch("suppressed_mask", got.suppressed_mask, want.suppressed_mask);
            if (got.empty_match_mask !== want.empty_match_mask)
                report_mismatch("empty_match_mask", got.empty_match_mask, want.empty_match_mask);
            if (got.status !== want.status)
                report_mismatch("status", {7'd0, got.status}, {7'd0, want.status});
        endtask
    endclass

endpackage

// File: test/trigger_slot_matcher_core_tb.sv
`timescale 1ns / 100ps

module trigger_slot_matcher_core_tb;
    import tsm_pkg::*;
    import slot_match_tb_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int IDLE_PCT        = 10;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STALL_LIMIT     = 1000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 215;
    // event results appear once the slot walk is done; give a margin
    // for a stray late result
    localparam int SETTLE_CYCLES   = TB_SLOTS + 12;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsm_req_if req_if ();
    tsm_rsp_if rsp_if ();
    tsm_cfg_if cfg_if ();

    trigger_slot_matcher_core #(.SLOTS(TB_SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    slot_match_tracker tracker = new();

    bit          steady      = 1'b0;  // suppress idling on both sides
    bit          hold_output = 1'b0;  // ask the receiver for a long hold-off
    logic [31:0] clock_ms;
    int          quiet_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check every accepted result; end the run if handshakes stop entirely.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) tracker.check_result(rsp_if.data);
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] stalled: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: stall at random, or hold off for a long stretch when asked
    // so the block fills up and has to refuse requests.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one request and return once it is accepted. Leave valid high so
    // back-to-back requests never drop and raise it within one time step.
    task automatic send_request(input t_req r);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        tracker.note_request(r);
    endtask

    // Stop offering and hold until every awaited result has come back.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        tracker.set_register(idx, value);
    endtask

    // Write both registers back to back, plus the unused index, then drop valid.
    task automatic write_settings(input logic [7:0] pct, input logic [15:0] window);
        logic [7:0] junk;
        junk = 8'($urandom);
        // upper bits of the threshold write carry noise; only the low byte counts
        write_register(CFG_DEFAULT_THRESHOLD, {junk, pct});
        write_register(CFG_GATHER_WINDOW, window);
        write_register(CFG_SPARE, 16'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_req req_of(logic [1:0] op, logic [7:0] id, logic [1:0] kind,
                                    logic [15:0] key, logic conf_on, logic [6:0] conf,
                                    logic [31:0] now, logic [15:0] min_gap,
                                    logic [7:0] pct, logic steps);
        t_req r;
        r.operation          = op;
        r.slot_id            = id;
        r.trigger_kind       = kind;
        r.key_value          = key;
        r.has_confidence     = conf_on;
        r.confidence_pct     = conf;
        r.now_ms             = now;
        r.min_gap_ms         = min_gap;
        r.slot_threshold_pct = pct;
        r.has_steps          = steps;
        return r;
    endfunction

    // Mostly a real slot, sometimes an id the block must refuse.
    function automatic logic [7:0] pick_slot_id();
        if ($urandom_range(9) != 0) return 8'($urandom_range(1, TB_SLOTS));
        return $urandom_range(1) ? 8'd0 : 8'($urandom_range(TB_SLOTS + 1, 255));
    endfunction

    // Small pool of keys so stored values and event values collide often.
    function automatic logic [15:0] common_key();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00A5;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        // fill every field with noise; each operation then shapes what it reads
        r.operation          = OP_EVENT;
        r.slot_id            = 8'($urandom);
        r.trigger_kind       = 2'($urandom);
        r.key_value          = 16'($urandom);
        r.has_confidence     = 1'($urandom);
        r.confidence_pct     = 7'($urandom_range(100));
        r.min_gap_ms         = 16'($urandom);
        r.slot_threshold_pct = 8'($urandom);
        r.has_steps          = 1'($urandom);
        // advance the wall clock; now and then jump anywhere or run up to the wrap
        if (pick < 2)
            clock_ms = $urandom;
        else if (pick < 4)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
        else if (pick >= 10)
            clock_ms = clock_ms + $urandom_range(1, 2500);
        r.now_ms = clock_ms;
        pick = $urandom_range(99);
        if (roll < 14) begin
            r.operation = OP_STORE;
            r.slot_id   = pick_slot_id();
            if (pick < 50) begin
                r.trigger_kind = KIND_GESTURE;
                // mostly a gesture set that can actually be gathered
                if (pick < 45) r.key_value = {11'd0, 4'($urandom_range(1, 15)), 1'b0};
            end else begin
                r.trigger_kind = (pick < 75) ? KIND_COMMAND :
                                 ($urandom_range(1) ? KIND_PLAIN_HI : KIND_PLAIN_LO);
                if (pick % 8 != 0) r.key_value = common_key();
            end
            pick = $urandom_range(9);
            if (pick < 4)
                r.min_gap_ms = 16'd0;
            else if (pick < 8)
                r.min_gap_ms = 16'($urandom_range(1, 3000));
            pick = $urandom_range(9);
            if (pick < 5)
                r.slot_threshold_pct = 8'd0;
            else if (pick < 8)
                r.slot_threshold_pct = 8'($urandom_range(20, 100));
        end else if (roll < 19) begin
            r.operation = OP_DELETE;
            r.slot_id   = pick_slot_id();
        end else if (roll < 22) begin
            r.operation = OP_NOP;
        end else if (pick < 55) begin
            r.trigger_kind   = KIND_GESTURE;
            r.has_confidence = (pick < 47);
            pick = $urandom_range(99);
            if (pick < 80)
                r.key_value = 16'($urandom_range(1, GESTURES));
            else if (pick < 90)
                r.key_value = {11'd0, 4'($urandom_range(1, 15)), 1'b0};
            else if (pick < 95)
                r.key_value = (pick % 2 != 0) ? 16'd0 : 16'(GESTURES + 1);
        end else begin
            r.trigger_kind = (pick < 78) ? KIND_COMMAND :
                             ($urandom_range(1) ? KIND_PLAIN_HI : KIND_PLAIN_LO);
            if (pick % 8 != 0) r.key_value = common_key();
        end
        return r;
    endfunction

    initial begin
        int phase;
        int n;
        // drive every input to a known value from time zero
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_DEFAULT_THRESHOLD;
        cfg_if.wdata <= '0;
        clock_ms = 32'd40000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset register values.
        // empty table: nothing can match yet
        send_request(req_of(OP_EVENT, 'hFF, KIND_GESTURE, 1, 1, 100, 0, 0, 0, 0));
        // bad ids on store and delete
        send_request(req_of(OP_STORE, 0, KIND_GESTURE, 'h6, 0, 0, 0, 0, 0, 1));
        send_request(req_of(OP_STORE, 8'(TB_SLOTS + 1), KIND_COMMAND, 1, 0, 0, 0, 0, 0, 1));
        send_request(req_of(OP_DELETE, 'hFF, KIND_COMMAND, 0, 0, 0, 0, 0, 0, 0));
        // no operation with every field at its top
        send_request(req_of(OP_NOP, 'hFF, KIND_PLAIN_HI, 'hFFFF, 1, 100, 32'hFFFF_FFFF,
                            'hFFFF, 'hFF, 1));
        // fill slots: gesture pair, command without steps, plain with top cooldown,
        // an ungatherable gesture set, and a four-gesture set with its own threshold
        send_request(req_of(OP_STORE, 1, KIND_GESTURE, 'h0006, 0, 0, 0, 0, 0, 1));
        send_request(req_of(OP_STORE, 2, KIND_COMMAND, 'hFFFF, 0, 0, 0, 1000, 'hFF, 0));
        send_request(req_of(OP_STORE, 8'(TB_SLOTS), KIND_PLAIN_HI, 0, 0, 0, 0, 'hFFFF, 0, 1));
        send_request(req_of(OP_STORE, 3, KIND_GESTURE, 'h0021, 0, 0, 0, 0, 0, 1));
        send_request(req_of(OP_STORE, 4, KIND_GESTURE, 'h001E, 0, 0, 0, 0, 90, 0));
        // just under, then at the default threshold; gather at time zero
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 1, 1, 49, 0, 0, 0, 0));
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 1, 1, 50, 0, 0, 0, 0));
        // zero stamp skips the window test: completes the pair
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 2, 1, 100, 6000, 0, 0, 0));
        // gestures outside the valid range
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 0, 1, 100, 6100, 0, 0, 0));
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 16'(GESTURES + 1), 1, 100, 6200,
                            0, 0, 0));
        // gesture without confidence matches on the exact value
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 'h0006, 0, 0, 6300, 0, 0, 0));
        // cooldown against a never-fired slot, then past it
        send_request(req_of(OP_EVENT, 0, KIND_COMMAND, 'hFFFF, 0, 0, 100, 0, 0, 0));
        send_request(req_of(OP_EVENT, 0, KIND_COMMAND, 'hFFFF, 0, 0, 7000, 0, 0, 0));
        // fire at the top of time, then inside cooldown across the wrap
        send_request(req_of(OP_EVENT, 0, KIND_PLAIN_HI, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
        send_request(req_of(OP_EVENT, 0, KIND_PLAIN_HI, 0, 0, 0, 10, 0, 0, 0));
        // window expiry, one past the limit
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 1, 1, 90, 20000, 0, 0, 0));
        send_request(req_of(OP_EVENT, 0, KIND_GESTURE, 3, 1, 95, 25001, 0, 0, 0));
        // delete, then the old trigger must be gone
        send_request(req_of(OP_DELETE, 8'(TB_SLOTS), KIND_PLAIN_LO, 0, 0, 0, 0, 0, 0, 0));
        send_request(req_of(OP_EVENT, 0, KIND_PLAIN_HI, 0, 0, 0, 30, 0, 0, 0));
        drain_results();

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: write_settings(8'd0, 16'd0);
                1: write_settings(8'd255, 16'hFFFF);
                2: write_settings(8'd1, 16'd1);
                3: write_settings(8'd100, 16'd200);
                default: write_settings(8'($urandom), 16'($urandom));
            endcase
            // one phase runs flat out with no idling anywhere
            steady = (phase == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 1 && n == 60) hold_output = 1'b1;
                send_request(random_request());
            end
            drain_results();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/tsm_pkg.sv
rtl/tsm_req_if.sv
rtl/tsm_rsp_if.sv
rtl/tsm_cfg_if.sv
rtl/tsm_ctrl.sv
rtl/tsm_dp.sv
rtl/trigger_slot_matcher_core.sv
test/slot_match_tb_pkg.sv
test/trigger_slot_matcher_core_tb.sv
